[rtl/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants for the palette color effect core
// Channel widths, grey constants, effect mode codes, register indexes and the level clamp.
// ----------------------------------------------------------------------------
package pce_pkg;

   // One color word holds three 5-bit channels.
   localparam int ChanW    = 5;
   localparam int NumChan  = 3;
   localparam int ColorW   = ChanW * NumChan;
   localparam int LevelW   = 5;
   localparam int FactorW  = LevelW + 1;
   localparam int ProdW    = ChanW + FactorW;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = LevelW;

   localparam logic [ChanW-1:0]  ChanMax  = 5'h1F;
   localparam logic [LevelW-1:0] LevelMax = 5'h10;

   // Grey value uses (sum * 205) >> 11, exact floor of sum / 10 for sum <= 310.
   localparam int GreySumW   = 9;
   localparam int GreyRecipW = 8;
   localparam int GreyProdW  = 16;
   localparam int GreyShift  = 11;
   localparam logic [GreyRecipW-1:0] GreyRecip = 8'd205;

   typedef enum logic [1:0] {
      MODE_DARKEN   = 2'd0,
      MODE_BRIGHTEN = 2'd1,
      MODE_TINT     = 2'd2,
      MODE_GREY     = 2'd3
   } effect_mode_type;

   // Register indexes of the write port.
   localparam logic [CsrIdxW-1:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_FADE_LEVEL  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_TINT_RED    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TINT_GREEN  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_TINT_BLUE   = 3'd4;

   // Levels above sixteen clamp to sixteen.
   function automatic logic [LevelW-1:0] sat_level(input logic [LevelW-1:0] v);
      return (v > LevelMax) ? LevelMax : v;
   endfunction

endpackage

[rtl/palette_color_effect_core.sv]
// ----------------------------------------------------------------------------
// palette_color_effect_core: RGB555 fade, tint and grey effect pipeline
// Applies darken, brighten, per-channel brighten or grayscale to each word.
// ----------------------------------------------------------------------------
//
//   Channel  Prefix  Handshake          Payload
//   input    req_    valid / ready      color_in, 15 bits
//   result   rsp_    valid / ready      color_out, 15 bits
//   config   csr_    write enable only  index 3 bits, data 5 bits
//
// An accepted word passes through stage 1 and stage 2 into the result register;
// one word can enter every cycle unless a result-side stall reaches the input.
// The depth is set by the per-channel multiply and the grey reciprocal
// multiply, which share the middle register stage.
// Reset clears the configuration registers and the valid bits; data registers are not reset.
// Each stage advances when it is empty or the stage after it moves, so a
// stall at the result side fills bubbles before the input side stops.
//
module palette_color_effect_core
   import pce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ColorW-1:0]   req_color_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ColorW-1:0]   rsp_color_out,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers.
   effect_mode_type   mode_ff;
   logic [LevelW-1:0] fade_ff;
   logic [LevelW-1:0] tint_ff [NumChan];

   // Stage 1: operand, factor and grey sum.
   logic                 v1_ff;
   effect_mode_type      s1_mode_ff;
   logic [ChanW-1:0]     s1_chan_ff [NumChan];
   logic [ChanW-1:0]     s1_opnd_ff [NumChan];
   logic [FactorW-1:0]   s1_fact_ff [NumChan];
   logic [GreySumW-1:0]  s1_sum_ff;
   logic [ChanW-1:0]     s1_opnd_in [NumChan];
   logic [FactorW-1:0]   s1_fact_in [NumChan];
   logic [GreySumW-1:0]  s1_sum_in;

   // Stage 2: scaled step per channel and grey product.
   logic                 v2_ff;
   effect_mode_type      s2_mode_ff;
   logic [ChanW-1:0]     s2_chan_ff [NumChan];
   logic [ChanW-1:0]     s2_step_ff [NumChan];
   logic [GreyProdW-1:0] s2_grey_ff;
   logic [ChanW-1:0]     s2_step_in [NumChan];
   logic [ProdW-1:0]     s2_prod    [NumChan];

   // Stage 3: result register.
   logic                 v3_ff;
   effect_mode_type      s3_mode_ff;
   logic [ColorW-1:0]    s3_color_ff;
   logic [ColorW-1:0]    s3_color_in;

   logic en1, en2, en3;

   // Stage enables: a stage loads when it is empty or its word moves on.
   always_comb begin
      en3 = !v3_ff || rsp_ready;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_ready     = en1;
   assign rsp_valid     = v3_ff;
   assign rsp_color_out = s3_color_ff;

   // Register writes; levels clamp on the way in.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DARKEN;
         fade_ff <= '0;
         for (int i = 0; i < NumChan; i++) begin
            tint_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EFFECT_MODE: mode_ff    <= effect_mode_type'(csr_wdata[1:0]);
            CSR_FADE_LEVEL:  fade_ff    <= sat_level(csr_wdata);
            CSR_TINT_RED:    tint_ff[0] <= sat_level(csr_wdata);
            CSR_TINT_GREEN:  tint_ff[1] <= sat_level(csr_wdata);
            CSR_TINT_BLUE:   tint_ff[2] <= sat_level(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stage 1 logic: brighten and tint work on the distance to white.
   always_comb begin
      logic [ChanW-1:0]  c;
      logic [LevelW-1:0] lvl;
      logic [ChanW-1:0]  r, g, b;
      for (int i = 0; i < NumChan; i++) begin
         c   = req_color_in[i*ChanW +: ChanW];
         lvl = (mode_ff == MODE_TINT) ? tint_ff[i] : fade_ff;
         s1_opnd_in[i] = (mode_ff == MODE_DARKEN) ? c : (ChanMax - c);
         s1_fact_in[i] = {lvl, 1'b0};
      end
      r = req_color_in[0*ChanW +: ChanW];
      g = req_color_in[1*ChanW +: ChanW];
      b = req_color_in[2*ChanW +: ChanW];
      s1_sum_in = {4'b0, r} + {4'b0, r} + {4'b0, r}
                + {3'b0, g, 1'b0} + {3'b0, g, 1'b0} + {3'b0, g, 1'b0}
                + {4'b0, b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff <= mode_ff;
         s1_sum_ff  <= s1_sum_in;
         for (int i = 0; i < NumChan; i++) begin
            s1_chan_ff[i] <= req_color_in[i*ChanW +: ChanW];
            s1_opnd_ff[i] <= s1_opnd_in[i];
            s1_fact_ff[i] <= s1_fact_in[i];
         end
      end
   end

   // Stage 2 logic: step = (operand * factor) >> 5, never above 31.
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         s2_prod[i]    = {{FactorW{1'b0}}, s1_opnd_ff[i]} * {{ChanW{1'b0}}, s1_fact_ff[i]};
         s2_step_in[i] = s2_prod[i][ChanW +: ChanW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_mode_ff <= s1_mode_ff;
         s2_grey_ff <= {{(GreyProdW-GreySumW){1'b0}}, s1_sum_ff}
                     * {{(GreyProdW-GreyRecipW){1'b0}}, GreyRecip};
         for (int i = 0; i < NumChan; i++) begin
            s2_chan_ff[i] <= s1_chan_ff[i];
            s2_step_ff[i] <= s2_step_in[i];
         end
      end
   end

   // Stage 3 logic: apply the step, or spread the grey value.
   always_comb begin
      logic [ChanW-1:0] grey;
      grey = s2_grey_ff[GreyShift +: ChanW];
      for (int i = 0; i < NumChan; i++) begin
         unique case (s2_mode_ff)
            MODE_DARKEN: s3_color_in[i*ChanW +: ChanW] = s2_chan_ff[i] - s2_step_ff[i];
            MODE_GREY:   s3_color_in[i*ChanW +: ChanW] = grey;
            default:     s3_color_in[i*ChanW +: ChanW] = s2_chan_ff[i] + s2_step_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_mode_ff  <= s2_mode_ff;
         s3_color_ff <= s3_color_in;
      end
   end

`ifndef ASSERT_OFF
   // Level registers never hold more than sixteen.
   a_level_clamp: assert property (@(posedge clock) disable iff (reset)
      fade_ff <= LevelMax && tint_ff[0] <= LevelMax &&
      tint_ff[1] <= LevelMax && tint_ff[2] <= LevelMax)
      else $error("level register above sixteen");

   // An accepted word reaches stage 1 on the next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word lost at stage 1");

   // A stalled middle stage keeps its word.
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !en3 |=> v2_ff && $stable(s2_grey_ff))
      else $error("stage 2 word dropped during stall");

   // Grayscale results carry the same value in all three channels.
   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      v3_ff && s3_mode_ff == MODE_GREY |->
      s3_color_ff[0 +: ChanW] == s3_color_ff[ChanW +: ChanW] &&
      s3_color_ff[0 +: ChanW] == s3_color_ff[2*ChanW +: ChanW])
      else $error("grey channels differ");
`endif

endmodule
